>>> hdl/min_variance_window_mean_top_assert.svh
// Assertion macros for the lowest-spread window mean block.
`ifndef MIN_VARIANCE_WINDOW_MEAN_TOP_ASSERT_SVH
`define MIN_VARIANCE_WINDOW_MEAN_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MVWM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mvwm assertion failed");

// Next-cycle implication, checked out of reset.
`define MVWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mvwm assertion failed");

`endif

>>> hdl/mvwm_pkg.sv
// Shared constants for the lowest-spread window mean block.
`default_nettype none
package mvwm_pkg;
    localparam int SAMPLE_W    = 24; // Q4.20 sample width
    localparam int SQ_W        = 47; // square of one sample, unsigned
    localparam int RECIP_SHIFT = 32; // fractional bits of the 1/WINDOW multiplier
endpackage
`default_nettype wire

>>> hdl/min_variance_window_mean_top.sv
// Lowest-spread window mean: five-register pipeline, one sample per clock when not stalled.
// A last-marked item passes stages 1 to 4, then the output register raises m_tvalid.
// Throughput: 1 item per cycle when not stalled; new samples enter before earlier ones finish.
// Input stalls only while a result waits and the next last-marked item sits in stage 4.
// Reset: aresetn synchronous, active low; clears valids, running sums, fill count and best window.
`default_nettype none
`include "min_variance_window_mean_top_assert.svh"
module min_variance_window_mean_top #(
    parameter int WINDOW = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [23:0] best_mean
    output logic             m_tuser    // [0] found
);
    localparam int SW     = mvwm_pkg::SAMPLE_W;
    localparam int QW     = mvwm_pkg::SQ_W;
    localparam int RS     = mvwm_pkg::RECIP_SHIFT;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SW + LOG_W;
    localparam int SQS_W  = QW + LOG_W;
    localparam int SPR_W  = QW + 2 * LOG_W;
    localparam int QP_W   = SUM_W + RS;
    localparam logic [RS:0] RECIP_FULL = ((({{RS{1'b0}}, 1'b1}) << RS) + (RS + 1)'(WINDOW) -
                                          (RS + 1)'(1)) / (RS + 1)'(WINDOW);
    localparam logic [RS-1:0] RECIP = RECIP_FULL[RS-1:0];

    // stage 1: input register
    logic                    v1_reg, last1_reg;
    logic signed [SW-1:0]    smp1_reg;
    // stage 2: sample and its square
    logic                    v2_reg, last2_reg;
    logic signed [SW-1:0]    smp2_reg;
    logic [QW-1:0]           sq2_reg;
    // stage 3: updated window sums
    logic                    v3_reg, last3_reg, full3_reg;
    logic signed [SUM_W-1:0] sum3_reg;
    logic [SQS_W-1:0]        sqs3_reg;
    // stage 4: products
    logic                    v4_reg, last4_reg, full4_reg, neg4_reg;
    logic [SPR_W-1:0]        wsq4_reg, ssq4_reg;
    logic [QP_W-1:0]         qp4_reg;

    // window state
    logic signed [SW-1:0]    win_reg [WINDOW];
    logic [QW-1:0]           winsq_reg [WINDOW];
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic [SQS_W-1:0]        sqs_reg, sqs_next, sqs_upd;
    logic                    full_old, full_new;

    // best window state
    logic [SPR_W-1:0]        best_spread_reg, best_spread_next;
    logic signed [SW-1:0]    best_mean_reg, best_mean_next;
    logic                    have_reg, have_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    out_mean_reg;
    logic                    out_found_reg;

    logic                    hold, adv;
    logic signed [2*SW-1:0]  sq_full;
    logic signed [2*SUM_W-1:0] ssq_full;
    logic [SUM_W-1:0]        mag3;
    logic [SPR_W-1:0]        spread;
    logic                    better;
    logic [SW-1:0]           q4;
    logic signed [SW-1:0]    new_mean, mean_now;
    logic                    found_now;

    // only a last item entering the output stage has to wait for the output register
    assign hold     = out_valid_reg && !m_tready && v4_reg && last4_reg;
    assign adv      = !hold;
    assign s_tready = aresetn && !hold;

    assign sq_full = smp1_reg * smp1_reg;

    // running sums
    always_comb begin
        full_old = (fill_reg == FILL_W'(WINDOW));
        full_new = full_old || (fill_reg == FILL_W'(WINDOW - 1));
        sum_upd  = sum_reg + SUM_W'(smp2_reg) - (full_old ? SUM_W'(win_reg[WINDOW-1]) : '0);
        sqs_upd  = sqs_reg + SQS_W'(sq2_reg) - (full_old ? SQS_W'(winsq_reg[WINDOW-1]) : '0);
        fill_next = fill_reg;
        sum_next  = sum_reg;
        sqs_next  = sqs_reg;
        if (v2_reg) begin
            if (last2_reg) begin
                fill_next = '0;
                sum_next  = '0;
                sqs_next  = '0;
            end else begin
                fill_next = full_old ? fill_reg : fill_reg + FILL_W'(1);
                sum_next  = sum_upd;
                sqs_next  = sqs_upd;
            end
        end
    end

    assign ssq_full = sum3_reg * sum3_reg;
    assign mag3     = sum3_reg[SUM_W-1] ? SUM_W'(-sum3_reg) : SUM_W'(sum3_reg);

    // best window compare and result
    always_comb begin
        spread    = wsq4_reg - ssq4_reg;
        better    = full4_reg && (spread < best_spread_reg);
        q4        = qp4_reg[RS +: SW];
        new_mean  = neg4_reg ? -$signed(q4) : $signed(q4);
        mean_now  = better ? new_mean : best_mean_reg;
        found_now = better || have_reg;
        best_spread_next = best_spread_reg;
        best_mean_next   = best_mean_reg;
        have_next        = have_reg;
        if (v4_reg) begin
            if (last4_reg) begin
                best_spread_next = '1;
                best_mean_next   = '0;
                have_next        = 1'b0;
            end else if (better) begin
                best_spread_next = spread;
                best_mean_next   = new_mean;
                have_next        = 1'b1;
            end
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (v4_reg && last4_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            fill_reg        <= '0;
            sum_reg         <= '0;
            sqs_reg         <= '0;
            best_spread_reg <= '1;
            best_mean_reg   <= '0;
            have_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (adv) begin
            v1_reg          <= s_tvalid;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            v4_reg          <= v3_reg;
            fill_reg        <= fill_next;
            sum_reg         <= sum_next;
            sqs_reg         <= sqs_next;
            best_spread_reg <= best_spread_next;
            best_mean_reg   <= best_mean_next;
            have_reg        <= have_next;
            out_valid_reg   <= out_valid_next;
        end else begin
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            smp1_reg  <= $signed(s_tdata);
            last1_reg <= s_tlast;

            smp2_reg  <= smp1_reg;
            last2_reg <= last1_reg;
            sq2_reg   <= QW'(unsigned'(sq_full));

            last3_reg <= last2_reg;
            full3_reg <= full_new;
            sum3_reg  <= sum_upd;
            sqs3_reg  <= sqs_upd;

            last4_reg <= last3_reg;
            full4_reg <= full3_reg;
            neg4_reg  <= sum3_reg[SUM_W-1];
            wsq4_reg  <= SPR_W'(sqs3_reg) * SPR_W'(WINDOW);
            ssq4_reg  <= SPR_W'(unsigned'(ssq_full));
            qp4_reg   <= QP_W'(mag3) * QP_W'(RECIP);

            if (v2_reg) begin
                win_reg[0]   <= smp2_reg;
                winsq_reg[0] <= sq2_reg;
                for (int i = 1; i < WINDOW; i++) begin
                    win_reg[i]   <= win_reg[i-1];
                    winsq_reg[i] <= winsq_reg[i-1];
                end
            end

            if (v4_reg && last4_reg) begin
                out_mean_reg  <= found_now ? mean_now : '0;
                out_found_reg <= found_now;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mean_reg;
    assign m_tuser  = out_found_reg;

    `MVWM_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, v4_reg && last4_reg && adv, out_valid_reg)
    `MVWM_ASSERT_NOW(a_not_found_zero, aclk, aresetn, out_valid_reg && !out_found_reg, out_mean_reg == '0)
    `MVWM_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(WINDOW))
    `MVWM_ASSERT_NEXT(a_best_shrinks, aclk, aresetn, v4_reg && !last4_reg && adv, best_spread_reg <= $past(best_spread_reg))
endmodule
`default_nettype wire
